[src/cda_pkg.sv]
`timescale 1ns / 1ps

package cda_pkg;

    // Field widths
    localparam int CDA_MONTH_W = 4;
    localparam int CDA_DAY_W   = 5;
    localparam int CDA_YEAR_W  = 14;
    localparam int CDA_DUR_W   = 13;

    // Year register carries one spare bit so that years past the field range still count
    localparam int CDA_YACC_W  = CDA_YEAR_W + 1;

    localparam int CDA_MAX_DURATION = 4096;

    // Operation codes
    localparam logic CDA_OP_ADD_DAYS = 1'b0;
    localparam logic CDA_OP_ONE_YEAR = 1'b1;

    // Calendar constants
    localparam logic [CDA_MONTH_W-1:0] CDA_JANUARY  = 4'd1;
    localparam logic [CDA_MONTH_W-1:0] CDA_FEBRUARY = 4'd2;
    localparam logic [CDA_MONTH_W-1:0] CDA_DECEMBER = 4'd12;
    localparam logic [CDA_YEAR_W-1:0]  CDA_YEAR_LIMIT = 14'd9999;

    // Year mod 400 through a reciprocal: q = (y * 5243) >> 21 is exact for 14-bit y
    localparam int CDA_CYCLE_W   = 9;
    localparam int CDA_QUOT_W    = 6;
    localparam int CDA_RECIP_W   = 13;
    localparam int CDA_RECIP_SH  = 21;
    localparam logic [CDA_RECIP_W-1:0] CDA_RECIP_400 = 13'd5243;
    localparam logic [CDA_CYCLE_W-1:0] CDA_CYCLE_400 = 9'd400;
    localparam logic [CDA_CYCLE_W-1:0] CDA_CYCLE_LAST = 9'd399;
    localparam logic [CDA_CYCLE_W-1:0] CDA_CENTURY_1 = 9'd100;
    localparam logic [CDA_CYCLE_W-1:0] CDA_CENTURY_2 = 9'd200;
    localparam logic [CDA_CYCLE_W-1:0] CDA_CENTURY_3 = 9'd300;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic calc_q;
        logic calc_r;
        logic step;
        logic year_end;
        logic capture;
    } cda_cmd_t;

    // Status back to the controller
    typedef struct packed {
        logic more;
        logic op;
    } cda_status_t;

    // Leap year from the year's position in the 400-year cycle
    function automatic logic cda_leap(input logic [CDA_CYCLE_W-1:0] pos);
        logic result;
        if (pos == '0)
            result = 1'b1;
        else if (pos == CDA_CENTURY_1 || pos == CDA_CENTURY_2 || pos == CDA_CENTURY_3)
            result = 1'b0;
        else
            result = (pos[1:0] == 2'b00);
        return result;
    endfunction

    // Days in a month; codes outside 1..12 count as 30-day months
    function automatic logic [CDA_DAY_W-1:0] cda_month_len(input logic [CDA_MONTH_W-1:0] m,
                                                           input logic leap);
        logic [CDA_DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd30;
        endcase
        return len;
    endfunction

    // Advance a position in the 400-year cycle by one year
    function automatic logic [CDA_CYCLE_W-1:0] cda_cycle_inc(input logic [CDA_CYCLE_W-1:0] pos);
        return (pos == CDA_CYCLE_LAST) ? '0 : pos + 1'b1;
    endfunction

endpackage

[src/calendar_date_adder.sv]
`timescale 1ns / 1ps
// Sequence: load, year mod 400 (quotient, then remainder), then for operation 0 one day
//   advanced per step, or for operation 1 a single year-end step; then capture.
// Requests are taken one at a time; the next is taken once the result is in the output
//   register, which may still wait on the output side.
// Reset: asynchronous, active low; clears the controller and the output valid.

module calendar_date_adder import cda_pkg::*; #(
    parameter int MAX_DURATION = CDA_MAX_DURATION
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   operation,
    input  logic [CDA_MONTH_W-1:0] start_month,
    input  logic [CDA_DAY_W-1:0]   start_day,
    input  logic [CDA_YEAR_W-1:0]  start_year,
    input  logic [CDA_DUR_W-1:0]   duration_days,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CDA_MONTH_W-1:0] end_month,
    output logic [CDA_DAY_W-1:0]   end_day,
    output logic [CDA_YEAR_W-1:0]  end_year,
    output logic                   year_overflow
);

    cda_cmd_t    cmd;
    cda_status_t status;

    cda_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    cda_datapath #(
        .MAX_DURATION (MAX_DURATION)
    ) u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .status        (status),
        .operation     (operation),
        .start_month   (start_month),
        .start_day     (start_day),
        .start_year    (start_year),
        .duration_days (duration_days),
        .end_month     (end_month),
        .end_day       (end_day),
        .end_year      (end_year),
        .year_overflow (year_overflow)
    );

`ifndef SYNTHESIS
    // An accepted request keeps the input side busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a request is in progress");

    // A saturated year always reports as the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && year_overflow |-> end_year == CDA_YEAR_LIMIT)
        else $error("overflow flagged without a saturated year");

    // A result appears only after a request was being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result raised without a request in progress");
`endif

endmodule

[src/cda_datapath.sv]
`timescale 1ns / 1ps

module cda_datapath import cda_pkg::*; #(
    parameter int MAX_DURATION = CDA_MAX_DURATION
) (
    input  logic                   clk,
    input  cda_cmd_t               cmd,
    output cda_status_t            status,
    input  logic                   operation,
    input  logic [CDA_MONTH_W-1:0] start_month,
    input  logic [CDA_DAY_W-1:0]   start_day,
    input  logic [CDA_YEAR_W-1:0]  start_year,
    input  logic [CDA_DUR_W-1:0]   duration_days,
    output logic [CDA_MONTH_W-1:0] end_month,
    output logic [CDA_DAY_W-1:0]   end_day,
    output logic [CDA_YEAR_W-1:0]  end_year,
    output logic                   year_overflow
);

    localparam int CNT_W = $clog2(MAX_DURATION + 1);
    localparam int CMP_W = (CNT_W > CDA_DUR_W) ? CNT_W : CDA_DUR_W;
    localparam int PROD_W = CDA_YEAR_W + CDA_RECIP_W;

    logic                   op_reg, op_next;
    logic [CDA_MONTH_W-1:0] month_reg, month_next;
    logic [CDA_DAY_W-1:0]   day_reg, day_next;
    logic [CDA_YACC_W-1:0]  year_reg, year_next;
    logic [CDA_CYCLE_W-1:0] cycle_reg, cycle_next;
    logic [CDA_QUOT_W-1:0]  quot_reg, quot_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [CDA_MONTH_W-1:0] end_month_reg;
    logic [CDA_DAY_W-1:0]   end_day_reg;
    logic [CDA_YEAR_W-1:0]  end_year_reg;
    logic                   year_overflow_reg;

    logic [CMP_W-1:0]       dur_cmp;
    logic [CMP_W-1:0]       dur_sat;
    logic [PROD_W-1:0]      recip_prod;
    logic [CDA_YEAR_W-1:0]  quot_scaled;
    logic [CDA_DAY_W:0]     day_inc;
    logic [CDA_MONTH_W:0]   month_inc;
    logic [CDA_CYCLE_W-1:0] cycle_plus;
    logic [CDA_MONTH_W-1:0] month_prev;
    logic                   year_past_limit;

    // Clamp the duration to the supported maximum
    always_comb
    begin
        dur_cmp = CMP_W'(duration_days);
        dur_sat = (dur_cmp > CMP_W'(MAX_DURATION)) ? CMP_W'(MAX_DURATION) : dur_cmp;
    end

    // Year mod 400: quotient by reciprocal, then remainder
    assign recip_prod  = PROD_W'(year_reg[CDA_YEAR_W-1:0]) * PROD_W'(CDA_RECIP_400);
    assign quot_scaled = CDA_YEAR_W'(quot_reg) * CDA_YEAR_W'(CDA_CYCLE_400);

    assign day_inc    = {1'b0, day_reg} + 1'b1;
    assign month_inc  = {1'b0, month_reg} + 1'b1;
    assign cycle_plus = cda_cycle_inc(cycle_reg);
    assign month_prev = month_reg - 1'b1;

    // Next-state logic for the working date
    always_comb
    begin
        op_next    = op_reg;
        month_next = month_reg;
        day_next   = day_reg;
        year_next  = year_reg;
        cycle_next = cycle_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        if (cmd.load)
        begin
            op_next    = operation;
            month_next = start_month;
            day_next   = start_day;
            year_next  = CDA_YACC_W'(start_year);
            cnt_next   = CNT_W'(dur_sat);
        end
        else if (cmd.calc_q)
        begin
            quot_next = recip_prod[CDA_RECIP_SH +: CDA_QUOT_W];
        end
        else if (cmd.calc_r)
        begin
            cycle_next = CDA_CYCLE_W'(year_reg[CDA_YEAR_W-1:0] - quot_scaled);
        end
        else if (cmd.step)
        begin
            // Advance one day, rolling month and year as needed
            cnt_next = cnt_reg - 1'b1;
            if (day_inc > {1'b0, cda_month_len(month_reg, cda_leap(cycle_reg))})
            begin
                day_next = CDA_DAY_W'(1);
                if (month_inc > {1'b0, CDA_DECEMBER})
                begin
                    month_next = CDA_JANUARY;
                    year_next  = year_reg + 1'b1;
                    cycle_next = cycle_plus;
                end
                else
                begin
                    month_next = month_inc[CDA_MONTH_W-1:0];
                end
            end
            else
            begin
                day_next = day_inc[CDA_DAY_W-1:0];
            end
        end
        else if (cmd.year_end)
        begin
            // Same date next year, minus one day
            if (day_reg <= CDA_DAY_W'(1))
            begin
                if (month_reg <= CDA_JANUARY)
                begin
                    month_next = CDA_DECEMBER;
                    day_next   = cda_month_len(CDA_DECEMBER, 1'b0);
                end
                else
                begin
                    month_next = month_prev;
                    day_next   = cda_month_len(month_prev, cda_leap(cycle_plus));
                    year_next  = year_reg + 1'b1;
                end
            end
            else
            begin
                day_next  = day_reg - 1'b1;
                year_next = year_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        year_reg  <= year_next;
        cycle_reg <= cycle_next;
        quot_reg  <= quot_next;
        cnt_reg   <= cnt_next;
    end

    // Capture the finished date, saturating the year
    assign year_past_limit = (year_reg > CDA_YACC_W'(CDA_YEAR_LIMIT));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            end_month_reg     <= month_reg;
            end_day_reg       <= day_reg;
            end_year_reg      <= year_past_limit ? CDA_YEAR_LIMIT
                                                 : year_reg[CDA_YEAR_W-1:0];
            year_overflow_reg <= year_past_limit;
        end
    end

    assign status.more   = (cnt_reg > CNT_W'(1));
    assign status.op     = op_reg;

    assign end_month     = end_month_reg;
    assign end_day       = end_day_reg;
    assign end_year      = end_year_reg;
    assign year_overflow = year_overflow_reg;

endmodule

[src/cda_controller.sv]
`timescale 1ns / 1ps

module cda_controller import cda_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    output cda_cmd_t    cmd,
    input  cda_status_t status
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_QUOT   = 3'd1;
    localparam logic [2:0] ST_REM    = 3'd2;
    localparam logic [2:0] ST_STEP   = 3'd3;
    localparam logic [2:0] ST_YEAR   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // Output register can take a new date when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_QUOT;
                end
            end
            ST_QUOT:
            begin
                cmd.calc_q = 1'b1;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                cmd.calc_r = 1'b1;
                state_next = (status.op == CDA_OP_ONE_YEAR) ? ST_YEAR : ST_STEP;
            end
            ST_STEP:
            begin
                // Advance one day per cycle until the count runs out
                if (status.more)
                    cmd.step = 1'b1;
                else
                    state_next = ST_FINISH;
            end
            ST_YEAR:
            begin
                cmd.year_end = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                // Hold the result until the output register frees up
                if (out_free)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
